// ----- design/lgps_pkg.sv -----
// Package with shared types and constants of the lookahead goal point search block.
package lgps_pkg;

  localparam int ROT_FRAC   = 14;
  localparam int SPEED_BITS = 12;
  localparam int LAP_BITS   = 9;
  localparam int OUT_COORD  = 24;

  typedef enum logic [1:0] {
    CMD_CLEAR      = 2'd0,
    CMD_APPEND_PRI = 2'd1,
    CMD_APPEND_ALT = 2'd2,
    CMD_QUERY      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SQRT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic sqrt_start;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_empty;
    logic sqrt_done;
  } stat_t;

endpackage

// ----- design/lgps_ctrl.sv -----
// Controller state machine of the goal point search.
module lgps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             query,
  input  logic             scan_empty,
  input  logic             out_free,
  input  lgps_pkg::stat_t  stat,
  output lgps_pkg::ctrl_t  ctrl,
  output logic             busy
);

  lgps_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lgps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl = '0;
    busy = 1'b1;
    unique case (state_r)
      lgps_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (query) begin
          ctrl.start = 1'b1;
          state_nxt = scan_empty ? lgps_pkg::ST_DRAIN : lgps_pkg::ST_SCAN;
        end
      end
      lgps_pkg::ST_SCAN: begin
        ctrl.issue = 1'b1;
        if (stat.scan_last) state_nxt = lgps_pkg::ST_DRAIN;
      end
      lgps_pkg::ST_DRAIN: begin
        if (stat.pipe_empty) begin
          ctrl.sqrt_start = 1'b1;
          state_nxt = lgps_pkg::ST_SQRT;
        end
      end
      lgps_pkg::ST_SQRT: begin
        if (stat.sqrt_done) state_nxt = lgps_pkg::ST_OUT;
      end
      lgps_pkg::ST_OUT: begin
        if (out_free) begin
          ctrl.load_out = 1'b1;
          state_nxt = lgps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lgps_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- design/lgps_path.sv -----
// Datapath: waypoint tables, frame transform, nearest search and square root.
module lgps_path #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_acc,
  input  lgps_pkg::cmd_t               cmd,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic [11:0]                  point_speed,
  input  logic signed [COORD_BITS-1:0] pose_x,
  input  logic signed [15:0]           rot_cos,
  input  logic signed [15:0]           rot_sin,
  input  logic signed [COORD_BITS-1:0] shift_x,
  input  logic signed [COORD_BITS-1:0] shift_y,
  input  logic [22:0]                  lookahead,
  input  logic [11:0]                  fixed_speed,
  input  logic                         use_table_speed,
  input  logic signed [23:0]           lap_line_x,
  input  logic [7:0]                   alternate_lap,
  input  lgps_pkg::ctrl_t              ctrl,
  output lgps_pkg::stat_t              stat,
  output logic                         scan_empty,
  output logic [23:0]                  goal_x,
  output logic [23:0]                  goal_y,
  output logic [23:0]                  goal_dist,
  output logic [11:0]                  goal_speed,
  output logic                         found,
  output logic [8:0]                   lap_number
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = AW + 1;
  localparam int EW  = 2 * COORD_BITS + 12;
  localparam int PW  = COORD_BITS + 17;
  localparam int DW  = 2 * COORD_BITS;
  localparam int RW  = COORD_BITS;
  localparam int LW  = (COORD_BITS > 24) ? COORD_BITS + 1 : 25;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (lgps_pkg::ROT_FRAC - 1);
  localparam logic signed [PW-1:0] CMAX = PW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [PW-1:0] CMIN = -(PW'(1) <<< (COORD_BITS - 1));

  logic [EW-1:0] pri_mem [TABLE_DEPTH];
  logic [EW-1:0] alt_mem [TABLE_DEPTH];
  logic [CW-1:0] pri_cnt_r, alt_cnt_r;
  logic signed [8:0] lap_r;
  logic lat_r;
  logic [CW-1:0] cnt_sel;
  logic use_alt;
  logic lap_inc, lap_clr;

  // Lap update for this pose, evaluated combinationally at accept.
  logic signed [LW-1:0] px_e, sl_e;
  assign px_e = LW'(pose_x);
  assign sl_e = LW'(lap_line_x);
  assign lap_inc = !lat_r && (px_e > sl_e);
  assign lap_clr = lat_r && (px_e < sl_e);
  logic signed [8:0] lap_new;
  assign lap_new = (lap_inc && lap_r != 9'sd255) ? lap_r + 9'sd1 : lap_r;
  assign use_alt = !lap_new[8] && (lap_new[7:0] == alternate_lap);
  assign cnt_sel = use_alt ? alt_cnt_r : pri_cnt_r;
  assign scan_empty = (cnt_sel == '0);

  wire q_start = ctrl.start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pri_cnt_r <= '0;
      alt_cnt_r <= '0;
      lap_r <= -9'sd1;
      lat_r <= 1'b0;
    end else if (item_acc) begin
      case (cmd)
        lgps_pkg::CMD_CLEAR: begin
          pri_cnt_r <= '0;
          alt_cnt_r <= '0;
        end
        lgps_pkg::CMD_APPEND_PRI: if (pri_cnt_r < DEPTH_C) pri_cnt_r <= pri_cnt_r + 1'b1;
        lgps_pkg::CMD_APPEND_ALT: if (alt_cnt_r < DEPTH_C) alt_cnt_r <= alt_cnt_r + 1'b1;
        default: begin
          lap_r <= lap_new;
          if (lap_inc) lat_r <= 1'b1;
          else if (lap_clr) lat_r <= 1'b0;
        end
      endcase
    end
  end

  logic [EW-1:0] wentry;
  assign wentry = {point_speed, point_y, point_x};

  always_ff @(posedge clk) begin
    if (item_acc && cmd == lgps_pkg::CMD_APPEND_PRI && pri_cnt_r < DEPTH_C)
      pri_mem[pri_cnt_r[AW-1:0]] <= wentry;
    if (item_acc && cmd == lgps_pkg::CMD_APPEND_ALT && alt_cnt_r < DEPTH_C)
      alt_mem[alt_cnt_r[AW-1:0]] <= wentry;
  end

  // Query context.
  logic alt_r;
  logic [CW-1:0] len_r, idx_r;
  logic signed [15:0] c_r, s_r;
  logic signed [COORD_BITS-1:0] tx_r, ty_r;
  always_ff @(posedge clk) begin
    if (q_start) begin
      alt_r <= use_alt;
      len_r <= cnt_sel;
      c_r <= rot_cos;
      s_r <= rot_sin;
      tx_r <= shift_x;
      ty_r <= shift_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else if (q_start) idx_r <= '0;
    else if (ctrl.issue) idx_r <= idx_r + 1'b1;
  end
  assign stat.scan_last = ctrl.issue && (idx_r + 1'b1 == len_r);

  // Pipeline: read, multiply, add/saturate, square, compare.
  logic v1_r, v2_r, v3_r, v4_r;
  logic [EW-1:0] rd_pri_r, rd_alt_r;
  always_ff @(posedge clk) begin
    rd_pri_r <= pri_mem[idx_r[AW-1:0]];
    rd_alt_r <= alt_mem[idx_r[AW-1:0]];
  end
  logic [EW-1:0] rd;
  assign rd = alt_r ? rd_alt_r : rd_pri_r;
  logic signed [COORD_BITS-1:0] wx, wy;
  assign wx = rd[COORD_BITS-1:0];
  assign wy = rd[2*COORD_BITS-1:COORD_BITS];

  logic signed [PW-1:0] cx_r, sy_r, sx_r, cy_r;
  logic [11:0] sp2_r, sp3_r, sp4_r;
  logic signed [COORD_BITS-1:0] vx_r, vy_r, vx4_r, vy4_r;
  logic [DW-1:0] xx_r, yy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      v1_r <= ctrl.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  logic signed [PW-1:0] rx, ry, fx, fy, vxs, vys;
  assign rx = cx_r - sy_r + HALF;
  assign ry = sx_r + cy_r + HALF;
  assign fx = (rx >>> lgps_pkg::ROT_FRAC) + PW'(tx_r);
  assign fy = (ry >>> lgps_pkg::ROT_FRAC) + PW'(ty_r);
  assign vxs = (fx > CMAX) ? CMAX : (fx < CMIN) ? CMIN : fx;
  assign vys = (fy > CMAX) ? CMAX : (fy < CMIN) ? CMIN : fy;

  logic [COORD_BITS-1:0] ax, ay;
  assign ax = vx_r;
  assign ay = vy_r[COORD_BITS-1] ? COORD_BITS'(-vy_r) : vy_r;

  always_ff @(posedge clk) begin
    cx_r <= PW'(c_r * wx);
    sy_r <= PW'(s_r * wy);
    sx_r <= PW'(s_r * wx);
    cy_r <= PW'(c_r * wy);
    sp2_r <= rd[EW-1:EW-12];
    vx_r <= vxs[COORD_BITS-1:0];
    vy_r <= vys[COORD_BITS-1:0];
    sp3_r <= sp2_r;
    xx_r <= DW'(ax) * DW'(ax);
    yy_r <= DW'(ay) * DW'(ay);
    vx4_r <= vx_r;
    vy4_r <= vy_r;
    sp4_r <= sp3_r;
  end
  logic neg4_r;
  always_ff @(posedge clk) neg4_r <= vx_r[COORD_BITS-1];

  logic [DW:0] d2;
  logic [45:0] la2;
  assign d2 = (DW+1)'(xx_r) + (DW+1)'(yy_r);
  assign la2 = 46'(lookahead) * 46'(lookahead);

  logic have_r;
  logic [DW:0] best_r;
  logic signed [COORD_BITS-1:0] bx_r, by_r;
  logic [11:0] bsp_r;
  logic take;
  assign take = v4_r && !neg4_r && ((DW+1+46)'(d2) > (DW+1+46)'(la2)) &&
                (!have_r || d2 < best_r);
  always_ff @(posedge clk) begin
    if (!rst_n) have_r <= 1'b0;
    else if (q_start) have_r <= 1'b0;
    else if (take) have_r <= 1'b1;
    if (take) begin
      best_r <= d2;
      bx_r <= vx4_r;
      by_r <= vy4_r;
      bsp_r <= use_table_speed ? sp4_r : fixed_speed;
    end
  end
  assign stat.pipe_empty = !(v1_r || v2_r || v3_r || v4_r);

  // Bit-pair square root, one result bit per cycle.
  localparam int SW = DW + 2;
  localparam int CTW = $clog2(RW + 1);
  logic [SW-1:0] rem_r;
  logic [RW+1:0] root_r;
  logic [SW-1:0] src_r;
  logic [CTW-1:0] sc_r;
  logic sq_busy_r;
  logic [SW-1:0] trial;
  logic [SW-1:0] rem_sh;
  assign rem_sh = {rem_r[SW-3:0], src_r[SW-1:SW-2]};
  assign trial = SW'({root_r, 2'b01});
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (ctrl.sqrt_start) begin
      sq_busy_r <= 1'b1;
      sc_r <= CTW'(RW + 1);
      rem_r <= '0;
      root_r <= '0;
      src_r <= SW'(best_r);
    end else if (sq_busy_r) begin
      src_r <= src_r << 2;
      if (rem_sh >= trial) begin
        rem_r <= rem_sh - trial;
        root_r <= {root_r[RW:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        root_r <= {root_r[RW:0], 1'b0};
      end
      sc_r <= sc_r - 1'b1;
      if (sc_r == CTW'(1)) sq_busy_r <= 1'b0;
    end
  end
  assign stat.sqrt_done = sq_busy_r && (sc_r == CTW'(1));

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      goal_x <= have_r ? 24'(bx_r) : '0;
      goal_y <= have_r ? 24'(by_r) : '0;
      goal_dist <= have_r ? 24'(root_r) : '0;
      goal_speed <= have_r ? bsp_r : '0;
      found <= have_r;
      lap_number <= lap_r;
    end
  end

endmodule

// ----- design/lookahead_goal_point_search_top.sv -----
// Top level of the lookahead goal point search block.
//
// channel  dir  handshake                 contents
// in       in   in_tvalid / in_tready     tuser command, tdata waypoint and pose
// out      out  out_tvalid / out_tready   tdata goal point, distance, speed, flags
// cfg      in   cfg_we                    cfg_index, cfg_wdata
//
// A query streams the selected table one entry per cycle through a five stage
// transform and compare pipeline, then runs a bit-serial square root of one result
// bit per cycle; an empty table skips the scan and goes on to the square root.
// Reset clears the counts and the lap state; table contents stay undefined.
// A waiting result blocks only the next query; appends are taken meanwhile.
module lookahead_goal_point_search_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_BITS  = 24,
  parameter int FRAC_BITS   = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,  // command
  // point_x, point_y, point_speed, pose_x, rot_cos, rot_sin, shift_x, shift_y, zero fill
  input  logic [((5*COORD_BITS+44+7)/8)*8-1:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // goal_x, goal_y, goal_dist, goal_speed, found, lap_number, zero fill
  output logic [95:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_wdata
);

  localparam int C = COORD_BITS;
  localparam logic [2:0] R_LA = 3'd0, R_FS = 3'd1, R_UTS = 3'd2, R_SL = 3'd3, R_AL = 3'd4;

  logic [22:0] la_r;
  logic [11:0] fs_r;
  logic uts_r;
  logic signed [23:0] sl_r;
  logic [7:0] al_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r <= 23'(1 << FRAC_BITS);
      fs_r <= 12'd512;
      uts_r <= 1'b0;
      sl_r <= -24'(11 << FRAC_BITS);
      al_r <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        R_LA: la_r <= cfg_wdata[22:0];
        R_FS: fs_r <= cfg_wdata[11:0];
        R_UTS: uts_r <= cfg_wdata[0];
        R_SL: sl_r <= cfg_wdata;
        R_AL: al_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  lgps_pkg::cmd_t cmd;
  assign cmd = lgps_pkg::cmd_t'(in_tuser);
  logic busy, item_acc, scan_empty;
  lgps_pkg::ctrl_t ctrl;
  lgps_pkg::stat_t stat;
  logic ov_r;

  assign in_tready = !busy && !(ov_r && cmd == lgps_pkg::CMD_QUERY);
  assign item_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (ctrl.load_out) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end
  assign out_tvalid = ov_r;

  logic [23:0] gx, gy, gd;
  logic [11:0] gs;
  logic gf;
  logic [8:0] ln;

  lgps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .query(item_acc && cmd == lgps_pkg::CMD_QUERY),
    .scan_empty(scan_empty), .out_free(!ov_r || out_tready),
    .stat(stat), .ctrl(ctrl), .busy(busy)
  );

  lgps_path #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_BITS(COORD_BITS)) u_path (
    .clk(clk), .rst_n(rst_n), .item_acc(item_acc), .cmd(cmd),
    .point_x(in_tdata[C-1:0]), .point_y(in_tdata[2*C-1:C]),
    .point_speed(in_tdata[2*C+11:2*C]), .pose_x(in_tdata[3*C+11:2*C+12]),
    .rot_cos(in_tdata[3*C+27:3*C+12]), .rot_sin(in_tdata[3*C+43:3*C+28]),
    .shift_x(in_tdata[4*C+43:3*C+44]), .shift_y(in_tdata[5*C+43:4*C+44]),
    .lookahead(la_r), .fixed_speed(fs_r), .use_table_speed(uts_r),
    .lap_line_x(sl_r), .alternate_lap(al_r), .ctrl(ctrl), .stat(stat),
    .scan_empty(scan_empty), .goal_x(gx), .goal_y(gy), .goal_dist(gd),
    .goal_speed(gs), .found(gf), .lap_number(ln)
  );

  assign out_tdata = {2'd0, ln, gf, gs, gd, gy, gx};

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the lookahead goal point search block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int CW = 24;
  localparam int TD_W = ((5*CW+44+7)/8)*8;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct {
    lgps_pkg::cmd_t cmd;
    logic [TD_W-1:0] data;
  } wp_item_t;

  typedef struct {
    logic [23:0] gx;
    logic [23:0] gy;
    logic [23:0] gdist;
    logic [11:0] speed;
    logic found;
    logic [8:0] lap;
  } goal_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [1:0] in_tuser = 0;
  logic [TD_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [23:0] cfg_wdata = 0;

  lookahead_goal_point_search_top DUT (.*);

  always #1 clk = ~clk;

  // Model state and configuration.
  longint pri_x[DEPTH], pri_y[DEPTH], alt_x[DEPTH], alt_y[DEPTH];
  int pri_spd[DEPTH], alt_spd[DEPTH];
  int pri_cnt, alt_cnt, lap_cnt;
  bit lap_armed;
  longint m_lookahead, m_fixed_speed, m_start_x;
  bit m_table_speed;
  int m_alt_lap;

  wp_item_t pend_q[$];
  goal_t goal_q[$];
  int errors = 0;
  longint cycles = 0;
  bit long_hold_req = 0;

  function automatic longint sat_coord(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic goal_t search_goal(logic [TD_W-1:0] d);
    goal_t g;
    longint px, c, s, tx, ty, wx, wy, vx, vy, bx, by;
    longint unsigned la2, d2, best;
    int n, bspd;
    bit alt, have;
    px = longint'($signed(d[83:60]));
    c = longint'($signed(d[99:84]));
    s = longint'($signed(d[115:100]));
    tx = longint'($signed(d[139:116]));
    ty = longint'($signed(d[163:140]));
    if (!lap_armed && px > m_start_x) begin
      if (lap_cnt < 255) lap_cnt++;
      lap_armed = 1;
    end else if (lap_armed && px < m_start_x) begin
      lap_armed = 0;
    end
    alt = (lap_cnt >= 0) && (lap_cnt == m_alt_lap);
    n = alt ? alt_cnt : pri_cnt;
    la2 = m_lookahead * m_lookahead;
    have = 0; best = 0; bx = 0; by = 0; bspd = 0;
    for (int i = 0; i < n; i++) begin
      wx = alt ? alt_x[i] : pri_x[i];
      wy = alt ? alt_y[i] : pri_y[i];
      vx = sat_coord(((c * wx - s * wy + 8192) >>> 14) + tx);
      vy = sat_coord(((s * wx + c * wy + 8192) >>> 14) + ty);
      if (vx < 0) continue;
      d2 = vx * vx + vy * vy;
      if (d2 > la2 && (!have || d2 < best)) begin
        have = 1; best = d2; bx = vx; by = vy;
        bspd = m_table_speed ? (alt ? alt_spd[i] : pri_spd[i]) : int'(m_fixed_speed);
      end
    end
    g.gx = have ? bx[23:0] : '0;
    g.gy = have ? by[23:0] : '0;
    g.gdist = have ? 24'(int_sqrt(best)) : '0;
    g.speed = have ? 12'(bspd) : '0;
    g.found = have;
    g.lap = 9'(lap_cnt);
    return g;
  endfunction

  task automatic apply_item(wp_item_t it);
    case (it.cmd)
      lgps_pkg::CMD_CLEAR: begin
        pri_cnt = 0;
        alt_cnt = 0;
      end
      lgps_pkg::CMD_APPEND_PRI: if (pri_cnt < DEPTH) begin
        pri_x[pri_cnt] = longint'($signed(it.data[23:0]));
        pri_y[pri_cnt] = longint'($signed(it.data[47:24]));
        pri_spd[pri_cnt] = int'(it.data[59:48]);
        pri_cnt++;
      end
      lgps_pkg::CMD_APPEND_ALT: if (alt_cnt < DEPTH) begin
        alt_x[alt_cnt] = longint'($signed(it.data[23:0]));
        alt_y[alt_cnt] = longint'($signed(it.data[47:24]));
        alt_spd[alt_cnt] = int'(it.data[59:48]);
        alt_cnt++;
      end
      lgps_pkg::CMD_QUERY: goal_q = {goal_q, search_goal(it.data)};
    endcase
  endtask

  // Driver: bursts of items with random gaps.
  bit taken = 0;
  int burst_left = 0, gap_left = 0;
  wp_item_t cur;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_tvalid && in_tready) begin
      apply_item(cur);
      taken = 1;
    end
  end

  always @(negedge clk) begin
    bit nv;
    nv = in_tvalid && !taken;
    if (rst_n && !nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend_q.size() > 0) begin
        cur = pend_q.pop_front();
        in_tuser <= cur.cmd;
        in_tdata <= cur.data;
        nv = 1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    taken = 0;
    in_tvalid <= nv;
  end

  // Receiver: random stall pattern, plus one long hold-off on request.
  int rx_mode = 0, rx_phase = 0, hold_left = 0;
  always @(negedge clk) begin
    bit r;
    if (long_hold_req && hold_left == 0) begin
      hold_left = 3000;
      long_hold_req = 0;
    end
    if (rx_phase == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_phase = $urandom_range(16, 96);
    end
    rx_phase--;
    case (rx_mode)
      0: r = 1;
      1: r = ($urandom_range(0, 3) != 0);
      2: r = ($urandom_range(0, 1) != 0);
      default: r = ($urandom_range(0, 7) == 0);
    endcase
    if (hold_left > 0) begin
      hold_left--;
      r = 0;
    end
    out_tready <= r;
  end

  task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // Monitor.
  always @(posedge clk) begin
    goal_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (goal_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual %h", $realtime, out_tdata);
      end else begin
        e = goal_q.pop_front();
        check_field("goal_x", e.gx, out_tdata[23:0]);
        check_field("goal_y", e.gy, out_tdata[47:24]);
        check_field("goal_dist", e.gdist, out_tdata[71:48]);
        check_field("goal_speed", 24'(e.speed), 24'(out_tdata[83:72]));
        check_field("found", 24'(e.found), 24'(out_tdata[84]));
        check_field("lap_number", 24'(e.lap), 24'(out_tdata[93:85]));
        check_field("zero_fill", 24'd0, 24'(out_tdata[95:94]));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push(lgps_pkg::cmd_t cmd, longint x, longint y, int spd, longint px,
                      longint c, longint s, longint sx, longint sy);
    wp_item_t it;
    it.cmd = cmd;
    it.data = TD_W'({sy[23:0], sx[23:0], s[15:0], c[15:0], px[23:0], spd[11:0], y[23:0],
                     x[23:0]});
    pend_q = {pend_q, it};
  endtask

  task automatic add_point(lgps_pkg::cmd_t cmd, longint x, longint y, int spd);
    push(cmd, x, y, spd, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic query(longint px, longint c, longint s, longint sx, longint sy);
    push(lgps_pkg::CMD_QUERY, $urandom, $urandom, $urandom, px, c, s, sx, sy);
  endtask

  task automatic wait_idle();
    while (pend_q.size() > 0 || in_tvalid || goal_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(int idx, longint v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx[2:0];
    cfg_wdata <= v[23:0];
    case (idx)
      0: m_lookahead = v & 64'h7FFFFF;
      1: m_fixed_speed = v & 64'hFFF;
      2: m_table_speed = v[0];
      3: m_start_x = longint'($signed(v[23:0]));
      default: m_alt_lap = int'(v & 64'hFF);
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic write_all(longint la, longint fs, longint ts, longint sl, longint al);
    write_reg(0, la);
    write_reg(1, fs);
    write_reg(2, ts);
    write_reg(3, sl);
    write_reg(4, al);
  endtask

  function automatic longint rnd_coord(bit wide);
    if (wide) return longint'($signed(24'($urandom)));
    return longint'($urandom_range(0, 163840)) - 81920;
  endfunction

  function automatic longint rnd_trig();
    return longint'($urandom_range(0, 32768)) - 16384;
  endfunction

  initial begin
    pri_cnt = 0; alt_cnt = 0; lap_cnt = -1; lap_armed = 0;
    m_lookahead = 4096; m_fixed_speed = 512; m_table_speed = 0;
    m_start_x = -45056; m_alt_lap = 2;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: empty tables, then edge-of-lookahead, ties, behind, saturation.
    query(-8388608, 16384, 0, 0, 0);
    query(8388607, 16384, 0, 0, 0);
    add_point(lgps_pkg::CMD_APPEND_PRI, -4096, 0, 100);
    add_point(lgps_pkg::CMD_APPEND_PRI, 4096, 0, 200);
    add_point(lgps_pkg::CMD_APPEND_PRI, 4097, 0, 300);
    add_point(lgps_pkg::CMD_APPEND_PRI, 0, 4097, 400);
    add_point(lgps_pkg::CMD_APPEND_PRI, 8388607, 8388607, 4095);
    add_point(lgps_pkg::CMD_APPEND_PRI, -8388608, -8388608, 0);
    add_point(lgps_pkg::CMD_APPEND_ALT, 20000, -3000, 777);
    query(-50000, 16384, 0, 0, 0);
    query(-8388608, -16384, 0, 0, 0);
    query(0, 16384, 16384, 8388607, -8388608);
    query(100, 0, -16384, -8388608, 8388607);
    query(-50000, 16384, 0, 0, 0);
    query(0, 16384, 0, 0, 0);
    query(0, 11585, -11585, 1234, -5678);
    push(lgps_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom);
    query(0, 16384, 0, 0, 0);
    wait_idle();

    write_all(0, 4095, 1, 0, 3);
    add_point(lgps_pkg::CMD_APPEND_PRI, 0, 0, 11);
    add_point(lgps_pkg::CMD_APPEND_PRI, 5, 0, 22);
    add_point(lgps_pkg::CMD_APPEND_ALT, 1, 1, 33);
    query(-10, 16384, 0, 0, 0);
    query(10, 16384, 0, 0, 0);
    wait_idle();

    // Lap counting through the alternate lap.
    write_all(4096, 1000, 0, 0, longint'((lap_cnt + 20) & 255));
    push(lgps_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    add_point(lgps_pkg::CMD_APPEND_ALT, 40000, 0, 5);
    add_point(lgps_pkg::CMD_APPEND_PRI, 30000, 0, 6);
    for (int i = 0; i < 40; i++) begin
      query(1, 16384, 0, 0, 0);
      query(i % 5 == 0 ? 0 : -1, 16384, 0, 0, 0);
    end
    wait_idle();
    write_all(4096, 512, 0, -8388608, 0);
    query(-8388608, 16384, 0, 0, 0);
    query(8388607, 16384, 0, 0, 0);
    wait_idle();

    // Random part, with a config change every block.
    for (int blk = 0; blk < 5; blk++) begin
      write_all(($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, 8388607))
                                            : longint'($urandom_range(0, 40000)),
                $urandom_range(0, 4095), $urandom_range(0, 1),
                longint'($urandom_range(0, 40000)) - 20000,
                $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 4));
      if (blk == 2) long_hold_req = 1;
      for (int k = 0; k < 86; k++) begin
        int op;
        op = $urandom_range(0, 99);
        if (op < 3 || (pri_cnt > 48 && op < 10)) begin
          push(lgps_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom);
        end else if (op < 40) begin
          add_point(op < 25 ? lgps_pkg::CMD_APPEND_PRI : lgps_pkg::CMD_APPEND_ALT,
                    rnd_coord(op % 7 == 0), rnd_coord(op % 7 == 0), $urandom);
        end else begin
          query(longint'($urandom_range(0, 40000)) - 20000 + m_start_x,
                op % 9 == 0 ? longint'($signed(16'($urandom))) : rnd_trig(),
                op % 9 == 0 ? longint'($signed(16'($urandom))) : rnd_trig(),
                rnd_coord(op % 5 == 0), rnd_coord(op % 5 == 0));
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lgps_pkg.sv
design/lgps_ctrl.sv
design/lgps_path.sv
design/lookahead_goal_point_search_top.sv
sim/tb.sv
